### rtl/lpdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpdr_pkg
// Shared types and constants of the length-prefixed deframer and reassembler.
// ----------------------------------------------------------------------------
package lpdr_pkg;

    localparam int BYTE_W           = 8;
    localparam int FRAME_LEN_W      = 16;
    localparam int TOTAL_W          = 32;
    localparam int DOC_LEN_BITS_DEF = 32;
    localparam int DOC_HDR_BYTES    = 4;

    typedef enum logic [2:0] {
        PH_HDR_HI = 3'b001,
        PH_HDR_LO = 3'b010,
        PH_BODY   = 3'b100
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              first;
        logic              last;
    } t_result;

endpackage

### rtl/lpdr_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpdr_in_stage
// Input register: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module lpdr_in_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [lpdr_pkg::BYTE_W-1:0] i_data,
    input  logic                        i_advance,
    output logic                        o_valid,
    output logic [lpdr_pkg::BYTE_W-1:0] o_data
);

    logic                        r_valid;
    logic [lpdr_pkg::BYTE_W-1:0] r_data;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

endmodule

### rtl/lpdr_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpdr_parser
// Frame header parser and message tracker: one byte per advance, gives the
// body byte with first and last of message marks.
// ----------------------------------------------------------------------------
module lpdr_parser #(
    parameter int DOC_LEN_BITS = lpdr_pkg::DOC_LEN_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,
    input  logic [lpdr_pkg::BYTE_W-1:0] i_byte,
    output logic                        o_res_valid,
    output lpdr_pkg::t_result           o_res
);

    localparam int FW = lpdr_pkg::FRAME_LEN_W;
    localparam int TW = lpdr_pkg::TOTAL_W;

    lpdr_pkg::t_phase        r_phase,     n_phase;
    logic [FW-1:0]           r_flen,      n_flen;
    logic [FW-1:0]           r_body_cnt,  n_body_cnt;
    logic                    r_cont,      n_cont;
    logic [DOC_LEN_BITS-1:0] r_doc_len,   n_doc_len;
    logic [TW-1:0]           r_total,     n_total;

    logic [FW-1:0]           body_inc;
    logic [TW-1:0]           part;
    logic [TW-1:0]           doc_ext;
    logic [TW-1:0]           frame_ext;
    logic                    first;
    logic                    last;

    always_comb begin
        n_phase     = r_phase;
        n_flen      = r_flen;
        n_body_cnt  = r_body_cnt;
        n_cont      = r_cont;
        n_doc_len   = r_doc_len;
        n_total     = r_total;
        first       = 1'b0;
        last        = 1'b0;
        o_res_valid = 1'b0;
        body_inc    = r_body_cnt + FW'(1);
        part        = TW'(i_byte) << {r_body_cnt[1:0], 3'b000};
        doc_ext     = '0;
        frame_ext   = TW'(r_flen);

        case (r_phase)
            lpdr_pkg::PH_HDR_LO: begin
                n_flen      = {r_flen[FW-1:8], i_byte};
                n_body_cnt  = '0;
                n_phase     = ({r_flen[FW-1:8], i_byte} == '0) ?
                              lpdr_pkg::PH_HDR_HI : lpdr_pkg::PH_BODY;
            end
            lpdr_pkg::PH_BODY: begin
                o_res_valid = 1'b1;
                if (!r_cont) begin
                    if (r_body_cnt == '0) begin
                        first     = 1'b1;
                        n_doc_len = '0;
                        n_total   = '0;
                    end
                    if (r_body_cnt < FW'(lpdr_pkg::DOC_HDR_BYTES)) begin
                        n_doc_len = n_doc_len | part[DOC_LEN_BITS-1:0];
                    end
                end
                if (n_total != '1) begin
                    n_total = n_total + TW'(1);
                end
                doc_ext    = TW'(n_doc_len);
                n_body_cnt = body_inc;
                if (body_inc >= r_flen) begin
                    if (r_cont) begin
                        if (n_total >= doc_ext) begin
                            last   = 1'b1;
                            n_cont = 1'b0;
                        end
                    end else if (r_flen >= FW'(lpdr_pkg::DOC_HDR_BYTES) &&
                                 doc_ext > frame_ext) begin
                        n_cont = 1'b1;
                    end else begin
                        last = 1'b1;
                    end
                    n_phase    = lpdr_pkg::PH_HDR_HI;
                    n_body_cnt = '0;
                end
            end
            default: begin
                n_flen      = {i_byte, 8'h00};
                n_phase     = lpdr_pkg::PH_HDR_LO;
            end
        endcase

        o_res.data  = i_byte;
        o_res.first = first;
        o_res.last  = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= lpdr_pkg::PH_HDR_HI;
            r_flen      <= '0;
            r_body_cnt  <= '0;
            r_cont      <= 1'b0;
            r_doc_len   <= '0;
            r_total     <= '0;
        end else if (i_advance) begin
            r_phase     <= n_phase;
            r_flen      <= n_flen;
            r_body_cnt  <= n_body_cnt;
            r_cont      <= n_cont;
            r_doc_len   <= n_doc_len;
            r_total     <= n_total;
        end
    end

endmodule

### rtl/length_prefixed_deframer_reassembler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_deframer_reassembler_core
// Length-prefixed frame deframer with multi-frame message reassembly.
//
// Slave channel: one stream byte per transfer. Each frame is a 2-byte
// big-endian length followed by that many body bytes.
// Master channel: one body byte per transfer; tuser marks the first byte
// of a message, tlast its final byte. Header bytes give no transfer.
// A message starts with a 4-byte little-endian document length; when the
// frame holds all 4 bytes and the length exceeds the frame length, the
// message continues over later frames until the byte count reaches it.
// Zero-length frames are dropped. A byte accepted into the input register
// passes the combinational parser into the result register that drives the
// master side. Throughput: one byte per cycle while the receiver does not stall.
// Reset clears the parser to expect a header byte and empties both
// registers. When the receiver stalls, the result register holds and the
// input register fills, then tready drops until the result is taken.
// ----------------------------------------------------------------------------
module length_prefixed_deframer_reassembler_core #(
    parameter int DOC_LEN_BITS = lpdr_pkg::DOC_LEN_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [lpdr_pkg::BYTE_W-1:0] i_s_axis_tdata,  // [7:0] in_byte
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [lpdr_pkg::BYTE_W-1:0] o_m_axis_tdata,  // [7:0] out_byte
    output logic                        o_m_axis_tuser,  // [0] first_of_message
    output logic                        o_m_axis_tlast
);

    logic                        in_valid;
    logic [lpdr_pkg::BYTE_W-1:0] in_byte;
    logic                        advance;
    logic                        res_valid;
    lpdr_pkg::t_result           res;

    logic                        r_out_valid;
    lpdr_pkg::t_result           r_out;

    assign advance = in_valid && (!r_out_valid || i_m_axis_tready);

    lpdr_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_data    (i_s_axis_tdata),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_data    (in_byte)
    );

    lpdr_parser #(
        .DOC_LEN_BITS (DOC_LEN_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_byte      (in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res_valid;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out.data;
    assign o_m_axis_tuser  = r_out.first;
    assign o_m_axis_tlast  = r_out.last;

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the length-prefixed deframer and reassembler.
//
// A short table of hand-built frames exercises empty frames, short messages
// and a message that spans frames and overruns its document length. Random
// traffic follows: mostly well-formed single- and multi-frame messages with
// random bodies, mixed with empty and short frames. A run closes with a message
// that announces the largest document length and never ends. Every body byte
// is predicted in the bench and compared with the master-side transfer stream
// under three idle patterns on the two channels.
// ----------------------------------------------------------------------------
module testbench;

    localparam int          DOC_BITS     = lpdr_pkg::DOC_LEN_BITS_DEF;
    localparam logic [31:0] DOC_MASK     = 32'((64'd1 << DOC_BITS) - 64'd1);
    localparam int          DRAIN_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int          N_ROWS       = 23;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_TYPED
    } t_chk;

    typedef struct packed {
        logic [7:0]        stim;
        t_chk              chk;
        lpdr_pkg::t_result want;
    } t_row;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       s_valid     = 1'b0;
    logic [7:0] s_data      = 8'h00;
    logic       m_ready     = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [7:0] m_data;
    logic       m_first;
    logic       m_last;

    int          src_gap_pct  = 0;
    int          sink_gap_pct = 0;
    int unsigned cycles       = 0;
    int unsigned errors       = 0;
    int unsigned bytes_sent   = 0;
    int unsigned frames_sent  = 0;
    int unsigned bytes_seen   = 0;
    int unsigned msgs_closed  = 0;

    // deframer state as predicted
    lpdr_pkg::t_phase ph        = lpdr_pkg::PH_HDR_HI;
    logic [15:0]      hdr_len   = '0;
    logic [15:0]      body_seen = '0;
    logic             spanning  = 1'b0;
    logic [31:0]      doc_len   = '0;
    logic [31:0]      msg_total = '0;

    lpdr_pkg::t_result pending_bytes[$];
    lpdr_pkg::t_result head_byte;

    t_row dir_rows [N_ROWS] = '{
        '{8'h00, CHK_NONE,  '0},                  // empty frame: drop
        '{8'h00, CHK_NONE,  '0},
        '{8'h00, CHK_NONE,  '0},
        '{8'h01, CHK_NONE,  '0},
        '{8'hFF, CHK_TYPED, '{8'hFF, 1'b1, 1'b1}}, // one-byte message
        '{8'h00, CHK_NONE,  '0},
        '{8'h03, CHK_NONE,  '0},
        '{8'h00, CHK_TYPED, '{8'h00, 1'b1, 1'b0}}, // short first frame
        '{8'h80, CHK_TYPED, '{8'h80, 1'b0, 1'b0}},
        '{8'h7F, CHK_TYPED, '{8'h7F, 1'b0, 1'b1}},
        '{8'h00, CHK_NONE,  '0},
        '{8'h04, CHK_NONE,  '0},
        '{8'h06, CHK_MODEL, '0},                  // document of 6 in a frame of 4
        '{8'h00, CHK_MODEL, '0},
        '{8'h00, CHK_MODEL, '0},
        '{8'h00, CHK_MODEL, '0},
        '{8'h00, CHK_NONE,  '0},                  // empty frame inside the message
        '{8'h00, CHK_NONE,  '0},
        '{8'h00, CHK_NONE,  '0},
        '{8'h03, CHK_NONE,  '0},
        '{8'hA5, CHK_MODEL, '0},                  // overrun: close on final byte
        '{8'h5A, CHK_MODEL, '0},
        '{8'hC3, CHK_MODEL, '0}
    };

    length_prefixed_deframer_reassembler_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // [7:0] in_byte
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),   // [7:0] out_byte
        .o_m_axis_tuser  (m_first),  // [0] first_of_message
        .o_m_axis_tlast  (m_last)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic void deframe_predict(input logic [7:0] b, output logic hit,
                                            output lpdr_pkg::t_result res);
        hit = 1'b0;
        res = '0;
        case (ph)
            lpdr_pkg::PH_HDR_LO: begin
                hdr_len[7:0] = b;
                body_seen    = '0;
                ph           = (hdr_len == '0) ? lpdr_pkg::PH_HDR_HI : lpdr_pkg::PH_BODY;
            end
            lpdr_pkg::PH_BODY: begin
                res.data = b;
                if (!spanning) begin
                    if (body_seen == '0) begin
                        res.first = 1'b1;
                        doc_len   = '0;
                        msg_total = '0;
                    end
                    if (body_seen < lpdr_pkg::DOC_HDR_BYTES) begin
                        doc_len = (doc_len | ({24'h0, b} << (8 * body_seen))) & DOC_MASK;
                    end
                end
                if (msg_total != '1) begin
                    msg_total = msg_total + 32'd1;
                end
                body_seen = 16'(body_seen + 16'd1);
                if (body_seen >= hdr_len) begin
                    if (spanning) begin
                        if (msg_total >= doc_len) begin
                            res.last = 1'b1;
                            spanning = 1'b0;
                        end
                    end else if (hdr_len >= lpdr_pkg::DOC_HDR_BYTES &&
                                 doc_len > 32'(hdr_len)) begin
                        spanning = 1'b1;
                    end else begin
                        res.last = 1'b1;
                    end
                    ph        = lpdr_pkg::PH_HDR_HI;
                    body_seen = '0;
                end
                hit = 1'b1;
            end
            default: begin
                hdr_len = {b, 8'h00};
                ph      = lpdr_pkg::PH_HDR_LO;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at cycle %0d: %s, got %0h, expected %0h", cycles, what, got, want);
        errors++;
    endtask

    // call at a falling edge; returns at the falling edge after the transfer
    task automatic put_byte(input logic [7:0] b, input t_chk chk,
                            input lpdr_pkg::t_result want);
        logic              hit;
        lpdr_pkg::t_result res;
        if ($urandom_range(0, 99) < src_gap_pct) begin
            s_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < src_gap_pct);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge i_clk); while (!s_ready);
        deframe_predict(b, hit, res);
        case (chk)
            CHK_MODEL: if (hit) pending_bytes.push_back(res);
            CHK_TYPED: pending_bytes.push_back(want);
            default: ;
        endcase
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_frame(input int unsigned len, input logic [31:0] doc_hdr);
        logic [7:0] b;
        put_byte(len[15:8], CHK_MODEL, '0);
        put_byte(len[7:0], CHK_MODEL, '0);
        for (int unsigned i = 0; i < len; i++) begin
            b = (i < lpdr_pkg::DOC_HDR_BYTES) ? doc_hdr[8*i +: 8] : 8'($urandom);
            put_byte(b, CHK_MODEL, '0);
        end
        frames_sent++;
    endtask

    task automatic random_traffic(input int unsigned budget);
        int unsigned sent;
        int unsigned pick;
        int unsigned len;
        int unsigned need;
        int unsigned got;
        sent = 0;
        while (sent < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_frame(0, $urandom);
            end else if (pick < 25) begin
                len = $urandom_range(1, 3);
                send_frame(len, $urandom);
                sent += len + 2;
            end else if (pick < 55) begin
                len = ($urandom_range(0, 24) == 0) ? $urandom_range(17, 700)
                                                   : $urandom_range(4, 16);
                send_frame(len, $urandom_range(0, len));
                sent += len + 2;
            end else begin
                need = $urandom_range(5, 64);
                len  = $urandom_range(4, need - 1);
                send_frame(len, need);
                sent += len + 2;
                got = len;
                while (got < need) begin
                    len = $urandom_range(0, 12);
                    send_frame(len, $urandom);
                    if (len != 0) sent += len + 2;
                    got += len;
                end
            end
        end
    endtask

    always @(negedge i_clk) begin
        m_ready <= ($urandom_range(0, 99) >= sink_gap_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) begin
            bytes_seen++;
            if (m_last) msgs_closed++;
            if (pending_bytes.size() == 0) begin
                report_mismatch("transfer with nothing expected", m_data, 'x);
            end else begin
                head_byte = pending_bytes.pop_front();
                if (m_data !== head_byte.data) report_mismatch("tdata", m_data, head_byte.data);
                if (m_first !== head_byte.first) report_mismatch("tuser", m_first, head_byte.first);
                if (m_last !== head_byte.last) report_mismatch("tlast", m_last, head_byte.last);
            end
        end
    end

    initial begin
        src_gap_pct  = 29;
        sink_gap_pct = 59;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_ROWS; i++) begin
            put_byte(dir_rows[i].stim, dir_rows[i].chk, dir_rows[i].want);
        end
        random_traffic(600);

        src_gap_pct  = 59;
        sink_gap_pct = 29;
        random_traffic(600);

        src_gap_pct  = 0;
        sink_gap_pct = 0;
        random_traffic(650);
        // largest document length: the message stays open to the end
        send_frame(6, 32'hFFFF_FFFF);
        send_frame(5, $urandom);
        s_valid <= 1'b0;

        while (pending_bytes.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (pending_bytes.size() != 0) begin
            report_mismatch("expected transfers never seen", 0, pending_bytes.size());
        end

        $display("sent %0d stream bytes in %0d random frames plus the directed table",
                 bytes_sent, frames_sent);
        $display("checked %0d body transfers, %0d messages closed, %0d mismatches",
                 bytes_seen, msgs_closed, errors);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/lpdr_pkg.sv
rtl/lpdr_in_stage.sv
rtl/lpdr_parser.sv
rtl/length_prefixed_deframer_reassembler_core.sv
verif/testbench.sv
